// File: design/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising edge outside reset.
`define ASSERT_AT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

// File: design/hfrdb_pkg.sv
package hfrdb_pkg;

    localparam int unsigned BANK_DEPTH  = 1048576;
    localparam int unsigned MSG_DEPTH   = 64;
    localparam int unsigned MAX_CHANNEL = 1024;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned LIMIT_W = 21;
    localparam int unsigned CHAN_W  = 11;
    localparam int unsigned COL_W   = 10;
    localparam int unsigned MLEN_W  = 6;
    localparam int unsigned POS_W   = 20;
    localparam int unsigned CFG_W   = 21;
    localparam int unsigned CIDX_W  = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(BANK_DEPTH);
    localparam logic [CHAN_W-1:0]  CHAN_MAX  = CHAN_W'(MAX_CHANNEL);
    localparam logic [MLEN_W-1:0]  MLEN_MAX  = MLEN_W'(MSG_DEPTH - 1);
    localparam logic [15:0]        END_MARKER_WORD = 16'h2323;

    typedef enum logic [1:0] {
        CMD_BYTE      = 2'd0,
        CMD_NEW_FILE  = 2'd1,
        CMD_SAVER_ACK = 2'd2,
        CMD_EXT_RESET = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_MSG_BYTE    = 3'd1,
        EV_MSG_END     = 3'd2,
        EV_SAMPLE      = 3'd3,
        EV_SAMPLE_HAND = 3'd4,
        EV_DATA_END    = 3'd5,
        EV_RESET       = 3'd6
    } event_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_BAD_HEX  = 3'd1,
        ERR_OVER_255 = 3'd2,
        ERR_THIRD_END = 3'd3,
        ERR_STRAY    = 3'd4,
        ERR_EXTERNAL = 3'd5
    } err_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_BANK_LIMIT   = 3'd0,
        CFG_CHANNEL_CNT  = 3'd1,
        CFG_MSG_START    = 3'd2,
        CFG_MSG_END      = 3'd3,
        CFG_DATA_START   = 3'd4,
        CFG_DATA_END     = 3'd5,
        CFG_READY        = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         event_res;
        logic [7:0]         byte_value;
        logic               bank;
        logic [POS_W-1:0]   position;
        logic [LIMIT_W-1:0] fill_count;
        logic [2:0]         error_code;
        logic               overrun;
        logic               first_in_bank;
    } out_item_t;

    // Limits are held already clamped to their legal ranges.
    typedef struct packed {
        logic [LIMIT_W-1:0] bank_limit;
        logic [CHAN_W-1:0]  channel_count;
        logic [7:0]         msg_start_code;
        logic [7:0]         msg_end_code;
        logic [7:0]         data_start_code;
        logic [7:0]         data_end_code;
        logic [7:0]         ready_code;
    } cfg_t;

    typedef struct packed {
        logic msg_end;
        logic msg_start;
        logic ready;
        logic dsec_open;
        logic dsec_close;
        logic hex_ok;
    } byte_class_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  rx_byte;
        byte_class_t cls;
        logic [3:0]  nibble;
    } front_item_t;

endpackage

// File: design/hfrdb_front.sv
module hfrdb_front
    import hfrdb_pkg::*;
(
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    input  cfg_t        cfg,
    input  logic        q_full,
    output logic        q_push,
    output front_item_t q_item
);

    logic [7:0] c;
    logic       is_dec;
    logic       is_uhex;

    assign c       = s_data.rx_byte;
    assign is_dec  = (c >= 8'h30) && (c <= 8'h39);
    assign is_uhex = (c >= 8'h41) && (c <= 8'h46);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_item.cmd            = cmd_t'(s_data.cmd);
        q_item.rx_byte        = c;
        q_item.cls.msg_end    = (c == cfg.msg_end_code);
        q_item.cls.msg_start  = (c == cfg.msg_start_code);
        q_item.cls.ready      = (c == cfg.ready_code);
        q_item.cls.dsec_open  = (c == cfg.data_start_code);
        q_item.cls.dsec_close = (c == cfg.data_end_code);
        q_item.cls.hex_ok     = is_dec || is_uhex;
        // 'A'..'F' low nibbles are 1..6, so add 9
        q_item.nibble         = is_dec ? c[3:0] : 4'(c[3:0] + 4'd9);
    end

endmodule

// File: design/hfrdb_queue.sv
module hfrdb_queue
    import hfrdb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  front_item_t push_item,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output front_item_t pop_item
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    front_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/hfrdb_back.sv
`include "assert_macros.svh"

module hfrdb_back
    import hfrdb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        q_not_empty,
    input  front_item_t q_item,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    logic               in_msg_reg,    in_msg_next;
    logic               in_data_reg,   in_data_next;
    logic [MLEN_W-1:0]  msg_len_reg,   msg_len_next;
    logic [11:0]        hex_acc_reg,   hex_acc_next;
    logic [1:0]         digits_reg,    digits_next;
    logic [1:0]         end_cnt_reg,   end_cnt_next;
    logic               active_reg,    active_next;
    logic [LIMIT_W-1:0] fill_reg,      fill_next;
    logic [COL_W-1:0]   col_reg,       col_next;
    logic               switch_reg,    switch_next;
    logic               save_reg,      save_next;
    logic               out_valid_reg;
    out_item_t          out_reg,       res;

    logic               fail;
    err_t               fail_err;
    logic [15:0]        word;
    logic [LIMIT_W-1:0] fill_inc;
    logic               boundary;

    logic               ext_pop;
    logic               hand_pop;
    logic               rx_idle;
    logic               hand_done;

    assign q_pop   = q_not_empty && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign word     = {hex_acc_reg, q_item.nibble};
    assign fill_inc = LIMIT_W'(fill_reg + 1'b1);
    assign boundary = (CHAN_W'({1'b0, col_reg} + 1'b1) >= cfg.channel_count);

    always_comb begin
        in_msg_next  = in_msg_reg;
        in_data_next = in_data_reg;
        msg_len_next = msg_len_reg;
        hex_acc_next = hex_acc_reg;
        digits_next  = digits_reg;
        end_cnt_next = end_cnt_reg;
        active_next  = active_reg;
        fill_next    = fill_reg;
        col_next     = col_reg;
        switch_next  = switch_reg;
        save_next    = save_reg;
        res          = '0;
        fail         = 1'b0;
        fail_err     = ERR_NONE;

        unique case (q_item.cmd)
            CMD_NEW_FILE: begin
                switch_next = 1'b1;
            end
            CMD_SAVER_ACK: begin
                save_next = 1'b0;
            end
            CMD_EXT_RESET: begin
                fail     = 1'b1;
                fail_err = ERR_EXTERNAL;
            end
            default: begin
                if (in_msg_reg && q_item.cls.msg_end) begin
                    res.event_res  = EV_MSG_END;
                    res.fill_count = LIMIT_W'(msg_len_reg);
                    msg_len_next   = '0;
                    in_msg_next    = 1'b0;
                end else if (!in_msg_reg && q_item.cls.msg_start) begin
                    msg_len_next = '0;
                    in_msg_next  = 1'b1;
                end else if (in_msg_reg) begin
                    res.event_res  = EV_MSG_BYTE;
                    res.byte_value = q_item.rx_byte;
                    res.position   = POS_W'(msg_len_reg);
                    if (msg_len_reg != MLEN_MAX) begin
                        msg_len_next = MLEN_W'(msg_len_reg + 1'b1);
                    end
                end else if (q_item.cls.ready) begin
                    res = '0;
                end else if (!in_data_reg && q_item.cls.dsec_open) begin
                    in_data_next = 1'b1;
                end else if (in_data_reg && q_item.cls.dsec_close) begin
                    res.event_res  = EV_DATA_END;
                    res.bank       = active_reg;
                    res.fill_count = fill_reg;
                    res.overrun    = save_reg;
                    in_data_next   = 1'b0;
                    hex_acc_next   = '0;
                    digits_next    = '0;
                    end_cnt_next   = '0;
                    save_next      = 1'b1;
                    fill_next      = '0;
                    col_next       = '0;
                end else if (in_data_reg) begin
                    if (!q_item.cls.hex_ok) begin
                        fail     = 1'b1;
                        fail_err = ERR_BAD_HEX;
                    end else if (digits_reg != 2'd3) begin
                        hex_acc_next = word[11:0];
                        digits_next  = 2'(digits_reg + 1'b1);
                    end else if (word == END_MARKER_WORD) begin
                        hex_acc_next = '0;
                        digits_next  = '0;
                        if (end_cnt_reg == 2'd2) begin
                            fail     = 1'b1;
                            fail_err = ERR_THIRD_END;
                        end else begin
                            end_cnt_next = 2'(end_cnt_reg + 1'b1);
                        end
                    end else if (word[15:8] != 8'h00) begin
                        fail     = 1'b1;
                        fail_err = ERR_OVER_255;
                    end else begin
                        res.byte_value    = word[7:0];
                        res.bank          = active_reg;
                        res.position      = fill_reg[POS_W-1:0];
                        res.first_in_bank = (fill_reg == '0);
                        hex_acc_next      = '0;
                        digits_next       = '0;
                        if ((fill_inc >= cfg.bank_limit) || (boundary && switch_reg)) begin
                            res.event_res  = EV_SAMPLE_HAND;
                            res.fill_count = fill_inc;
                            res.overrun    = save_reg;
                            save_next      = 1'b1;
                            active_next    = !active_reg;
                            fill_next      = '0;
                            col_next       = '0;
                            switch_next    = 1'b0;
                        end else begin
                            res.event_res = EV_SAMPLE;
                            fill_next     = fill_inc;
                            col_next      = boundary ? '0 : COL_W'(col_reg + 1'b1);
                        end
                    end
                end else begin
                    fail     = 1'b1;
                    fail_err = ERR_STRAY;
                end
            end
        endcase

        // receiver reset keeps switch request and registers
        if (fail) begin
            in_msg_next    = 1'b0;
            in_data_next   = 1'b0;
            msg_len_next   = '0;
            hex_acc_next   = '0;
            digits_next    = '0;
            end_cnt_next   = '0;
            active_next    = 1'b0;
            fill_next      = '0;
            col_next       = '0;
            save_next      = 1'b0;
            res            = '0;
            res.event_res  = EV_RESET;
            res.error_code = fail_err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_msg_reg    <= 1'b0;
            in_data_reg   <= 1'b0;
            msg_len_reg   <= '0;
            hex_acc_reg   <= '0;
            digits_reg    <= '0;
            end_cnt_reg   <= '0;
            active_reg    <= 1'b0;
            fill_reg      <= '0;
            col_reg       <= '0;
            switch_reg    <= 1'b0;
            save_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                in_msg_reg  <= in_msg_next;
                in_data_reg <= in_data_next;
                msg_len_reg <= msg_len_next;
                hex_acc_reg <= hex_acc_next;
                digits_reg  <= digits_next;
                end_cnt_reg <= end_cnt_next;
                active_reg  <= active_next;
                fill_reg    <= fill_next;
                col_reg     <= col_next;
                switch_reg  <= switch_next;
                save_reg    <= save_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= res;
        end
    end

    assign ext_pop   = q_pop && (q_item.cmd == CMD_EXT_RESET);
    assign hand_pop  = q_pop && (res.event_res == EV_SAMPLE_HAND);
    assign rx_idle   = !in_data_reg && !in_msg_reg;
    assign hand_done = (fill_reg == '0) && (col_reg == '0) && save_reg && !switch_reg;

    `ASSERT_NEVER(a_end_cnt_range, aclk, aresetn, end_cnt_reg == 2'd3)
    `ASSERT_AT(a_ext_reset, aclk, aresetn, ext_pop |=> (out_reg.error_code == ERR_EXTERNAL && rx_idle))
    `ASSERT_AT(a_hand_clears, aclk, aresetn, hand_pop |=> hand_done)

endmodule

// File: design/hex_frame_receiver_double_bank_unit.sv
// Path: an accepted beat is written to a queue slot, then the back end registers its
// result in the output stage. Throughput: one input beat per cycle while the queue has
// room; the back end takes one queued beat per cycle unless m_ready stalls its output.
// A two-entry queue sits between the classifier and the back end.
// Reset: synchronous, active low; clears receiver state, queue and output stage,
// and loads the configuration registers with their defaults.
module hex_frame_receiver_double_bank_unit
    import hfrdb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data
);

    // Configuration, held clamped so the back end compares directly
    cfg_t cfg_reg, cfg_next;

    logic [LIMIT_W-1:0] lim_clamped;
    logic [CHAN_W-1:0]  chan_clamped;

    always_comb begin
        // bank limit clamped to 1 .. bank depth
        if (cfg_wdata[LIMIT_W-1:0] == '0) begin
            lim_clamped = LIMIT_W'(1);
        end else if (cfg_wdata[LIMIT_W-1:0] > LIMIT_MAX) begin
            lim_clamped = LIMIT_MAX;
        end else begin
            lim_clamped = cfg_wdata[LIMIT_W-1:0];
        end
        // row length clamped to 1 .. max channels
        if (cfg_wdata[CHAN_W-1:0] == '0) begin
            chan_clamped = CHAN_W'(1);
        end else if (cfg_wdata[CHAN_W-1:0] > CHAN_MAX) begin
            chan_clamped = CHAN_MAX;
        end else begin
            chan_clamped = cfg_wdata[CHAN_W-1:0];
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BANK_LIMIT:  cfg_next.bank_limit      = lim_clamped;
                CFG_CHANNEL_CNT: cfg_next.channel_count   = chan_clamped;
                CFG_MSG_START:   cfg_next.msg_start_code  = cfg_wdata[7:0];
                CFG_MSG_END:     cfg_next.msg_end_code    = cfg_wdata[7:0];
                CFG_DATA_START:  cfg_next.data_start_code = cfg_wdata[7:0];
                CFG_DATA_END:    cfg_next.data_end_code   = cfg_wdata[7:0];
                CFG_READY:       cfg_next.ready_code      = cfg_wdata[7:0];
                default:         cfg_next = cfg_reg;   // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bank_limit      <= LIMIT_MAX;
            cfg_reg.channel_count   <= CHAN_W'(200);
            cfg_reg.msg_start_code  <= 8'd36;
            cfg_reg.msg_end_code    <= 8'd13;
            cfg_reg.data_start_code <= 8'd1;
            cfg_reg.data_end_code   <= 8'd2;
            cfg_reg.ready_code      <= 8'd3;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: accepts beats and tags each byte against the control codes
    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_not_empty;
    front_item_t q_in_item;
    front_item_t q_out_item;

    hfrdb_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_in_item)
    );

    // Decoupling queue
    hfrdb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_out_item)
    );

    // Back end: message/data state, hex decode, bank fill and handover,
    // plus the registered result stage
    hfrdb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_item      (q_out_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// File: tb/hex_frame_receiver_double_bank_unit_tb.sv
`default_nettype none

module hex_frame_receiver_double_bank_unit_tb;
    import hfrdb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CIDX_W-1:0] cfg_index = CFG_BANK_LIMIT;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    in_item_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    out_item_t         m_data;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    hex_frame_receiver_double_bank_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // ------------------------------------------------------------------
    // Shared run state
    // ------------------------------------------------------------------
    out_item_t expected_events[$];   // one per accepted beat, oldest first
    int        mismatch_count = 0;
    int        beats_sent     = 0;
    int        beats_checked  = 0;
    bit        idle_en        = 1'b1; // random gaps on both channels when set

    // Register copy, held raw as written; limits are clamped where they are used.
    logic [LIMIT_W-1:0] set_limit;
    logic [CHAN_W-1:0]  set_chans;
    logic [7:0]         set_msg_start;
    logic [7:0]         set_msg_end;
    logic [7:0]         set_data_start;
    logic [7:0]         set_data_end;
    logic [7:0]         set_ready;

    // Receiver state as the predictor sees it.
    logic               rx_in_msg;
    logic               rx_in_data;
    logic [MLEN_W-1:0]  rx_msg_len;
    logic [15:0]        rx_hex;
    logic [2:0]         rx_digits;
    logic [1:0]         rx_markers;
    logic               rx_bank;
    logic [LIMIT_W-1:0] rx_fill;
    logic [COL_W-1:0]   rx_col;
    logic               rx_switch_req;  // new-file request waiting for a row end
    logic               rx_saver_busy;  // handed-over bank not yet acknowledged

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Full receiver reset: the switch request and the registers survive it.
    function automatic out_item_t receiver_abort(input err_t why);
        out_item_t r;
        r             = '0;
        rx_in_msg     = 1'b0;
        rx_in_data    = 1'b0;
        rx_msg_len    = '0;
        rx_hex        = '0;
        rx_digits     = '0;
        rx_markers    = '0;
        rx_bank       = 1'b0;
        rx_fill       = '0;
        rx_col        = '0;
        rx_saver_busy = 1'b0;
        r.event_res   = EV_RESET;
        r.error_code  = why;
        return r;
    endfunction

    function automatic out_item_t rx_predict(input in_item_t beat);
        out_item_t   r;
        logic [7:0]  c;
        logic [3:0]  nib;
        logic [15:0] word;
        logic        row_end;
        int          lim;
        int          chans;
        r = '0;
        c = beat.rx_byte;
        lim = int'(set_limit);
        if (lim < 1) lim = 1;
        if (lim > int'(BANK_DEPTH)) lim = int'(BANK_DEPTH);
        chans = int'(set_chans);
        if (chans < 1) chans = 1;
        if (chans > int'(MAX_CHANNEL)) chans = int'(MAX_CHANNEL);

        if (beat.cmd == CMD_NEW_FILE) begin
            rx_switch_req = 1'b1;
        end else if (beat.cmd == CMD_SAVER_ACK) begin
            rx_saver_busy = 1'b0;
        end else if (beat.cmd == CMD_EXT_RESET) begin
            r = receiver_abort(ERR_EXTERNAL);
        // serial byte: message codes win over everything else
        end else if (rx_in_msg && c == set_msg_end) begin
            r.event_res  = EV_MSG_END;
            r.fill_count = LIMIT_W'(rx_msg_len);
            rx_msg_len   = '0;
            rx_in_msg    = 1'b0;
        end else if (!rx_in_msg && c == set_msg_start) begin
            rx_msg_len = '0;
            rx_in_msg  = 1'b1;
        end else if (rx_in_msg) begin
            r.event_res  = EV_MSG_BYTE;
            r.byte_value = c;
            r.position   = POS_W'(rx_msg_len);
            if (rx_msg_len < MLEN_MAX) rx_msg_len = rx_msg_len + 1'b1;
        end else if (c == set_ready) begin
            // ready byte outside a message: nothing to do
        end else if (!rx_in_data && c == set_data_start) begin
            rx_in_data = 1'b1;
        end else if (rx_in_data && c == set_data_end) begin
            // hand over the active bank even when it is empty
            r.event_res   = EV_DATA_END;
            r.bank        = rx_bank;
            r.fill_count  = rx_fill;
            r.overrun     = rx_saver_busy;
            rx_in_data    = 1'b0;
            rx_hex        = '0;
            rx_digits     = '0;
            rx_markers    = '0;
            rx_saver_busy = 1'b1;
            rx_fill       = '0;
            rx_col        = '0;
        end else if (!rx_in_data) begin
            r = receiver_abort(ERR_STRAY);
        // uppercase hex only: '0'..'9' and 'A'..'F'
        end else if (!((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46))) begin
            r = receiver_abort(ERR_BAD_HEX);
        end else begin
            nib       = (c <= 8'h39) ? 4'(c - 8'h30) : 4'(c - 8'h37);
            rx_hex    = {rx_hex[11:0], nib};
            rx_digits = rx_digits + 1'b1;
            if (rx_digits == 3'd4) begin
                word      = rx_hex;
                rx_hex    = '0;
                rx_digits = '0;
                if (word == END_MARKER_WORD) begin
                    rx_markers = rx_markers + 1'b1;
                    if (rx_markers > 2'd2) r = receiver_abort(ERR_THIRD_END);
                end else if (word > 16'h00FF) begin
                    r = receiver_abort(ERR_OVER_255);
                end else begin
                    r.event_res     = EV_SAMPLE;
                    r.byte_value    = word[7:0];
                    r.bank          = rx_bank;
                    r.position      = rx_fill[POS_W-1:0];
                    r.first_in_bank = (rx_fill == '0);
                    rx_fill         = rx_fill + 1'b1;
                    row_end         = (int'(rx_col) + 1 >= chans);
                    rx_col          = row_end ? '0 : rx_col + 1'b1;
                    // bank full, or a row finished after a new-file request
                    if (int'(rx_fill) >= lim || (row_end && rx_switch_req)) begin
                        r.event_res   = EV_SAMPLE_HAND;
                        r.fill_count  = rx_fill;
                        r.overrun     = rx_saver_busy;
                        rx_saver_busy = 1'b1;
                        rx_bank       = ~rx_bank;
                        rx_fill       = '0;
                        rx_col        = '0;
                        rx_switch_req = 1'b0;
                    end
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Register write, one clock with the enable high; only while the block is idle.
    task automatic cfg_write(input cfg_idx_t idx, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_BANK_LIMIT:  set_limit      = LIMIT_W'(value);
            CFG_CHANNEL_CNT: set_chans      = CHAN_W'(value);
            CFG_MSG_START:   set_msg_start  = 8'(value);
            CFG_MSG_END:     set_msg_end    = 8'(value);
            CFG_DATA_START:  set_data_start = 8'(value);
            CFG_DATA_END:    set_data_end   = 8'(value);
            CFG_READY:       set_ready      = 8'(value);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // One input beat. Valid is left high on return so that back-to-back beats
    // never lower and raise it in the same step; drain_results drops it.
    task automatic send_item(input cmd_t cmd, input logic [7:0] value);
        in_item_t beat;
        beat.cmd     = cmd;
        beat.rx_byte = value;
        while (idle_en && $urandom_range(0, 99) < 23) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        expected_events.push_back(rx_predict(beat));
    endtask

    task automatic send_byte(input logic [7:0] value);
        send_item(CMD_BYTE, value);
    endtask

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h37 + 8'(nib);
    endfunction

    // Four uppercase digits, most significant first.
    task automatic send_sample_word(input logic [15:0] word);
        for (int i = 3; i >= 0; i--) send_byte(hex_ascii(word[4*i +: 4]));
    endtask

    // Sender holds off until every beat sent so far has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Mostly well-formed data sections and messages, with some commands,
    // noise and deliberately broken sequences mixed in.
    task automatic send_random_frame();
        int          pick;
        int          n;
        logic [15:0] word;
        logic [7:0]  c;
        pick = $urandom_range(0, 19);
        if (pick <= 8) begin
            n = $urandom_range(1, 14);
            send_byte(set_data_start);
            for (int k = 0; k < n; k++) begin
                case ($urandom_range(0, 19))
                    0: send_sample_word(END_MARKER_WORD);
                    1: send_item(CMD_NEW_FILE, 8'($urandom_range(0, 255)));
                    2: send_item(CMD_SAVER_ACK, 8'($urandom_range(0, 255)));
                    3: send_sample_word(16'h00FF);
                    4: send_sample_word(16'h0000);
                    default: send_sample_word(16'($urandom_range(0, 255)));
                endcase
            end
            if ($urandom_range(0, 9) != 0) send_byte(set_data_end);
        end else if (pick <= 12) begin
            // an occasional long one runs the length counter into saturation
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 12);
            send_byte(set_msg_start);
            for (int k = 0; k < n; k++) begin
                c = 8'($urandom_range(0, 255));
                if (c == set_msg_end) c = c ^ 8'h01;
                send_byte(c);
            end
            send_byte(set_msg_end);
        end else if (pick == 13) begin
            send_item(CMD_NEW_FILE, 8'($urandom_range(0, 255)));
        end else if (pick == 14) begin
            send_item(CMD_SAVER_ACK, 8'($urandom_range(0, 255)));
        end else if (pick == 15) begin
            send_byte(set_ready);
        end else if (pick <= 17) begin
            case ($urandom_range(0, 5))
                0: begin
                    send_byte(set_data_start);
                    send_byte(8'($urandom_range(0, 255)));
                end
                1: begin
                    word = 16'($urandom_range(256, 65535));
                    if (word == END_MARKER_WORD) word = 16'hFFFF;
                    send_byte(set_data_start);
                    send_sample_word(word);
                end
                2: begin
                    send_byte(set_data_start);
                    repeat (3) send_sample_word(END_MARKER_WORD);
                end
                3: send_item(CMD_EXT_RESET, 8'($urandom_range(0, 255)));
                4: send_byte(8'($urandom_range(0, 255)));
                default: begin
                    // part of a word, then the section closes
                    send_byte(set_data_start);
                    repeat ($urandom_range(1, 3)) send_byte(hex_ascii(4'($urandom_range(0, 15))));
                    send_byte(set_data_end);
                end
            endcase
        end else begin
            send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_traffic(input int beats);
        int stop_at;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) send_random_frame();
    endtask

    // Codes that often land on hex digits or on each other.
    function automatic logic [7:0] clash_code();
        case ($urandom_range(0, 3))
            0: return hex_ascii(4'($urandom_range(0, 15)));
            1: return 8'($urandom_range(0, 7));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 60)
            $display("beat %0d: %s mismatch, got %0h want %0h", beats_checked, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch("unexpected beat", m_data.event_res, '0);
            end else begin
                want = expected_events.pop_front();
                if (m_data.event_res !== want.event_res)
                    report_mismatch("event_res", m_data.event_res, want.event_res);
                if (m_data.byte_value !== want.byte_value)
                    report_mismatch("byte_value", m_data.byte_value, want.byte_value);
                if (m_data.bank !== want.bank)
                    report_mismatch("bank", m_data.bank, want.bank);
                if (m_data.position !== want.position)
                    report_mismatch("position", m_data.position, want.position);
                if (m_data.fill_count !== want.fill_count)
                    report_mismatch("fill_count", m_data.fill_count, want.fill_count);
                if (m_data.error_code !== want.error_code)
                    report_mismatch("error_code", m_data.error_code, want.error_code);
                if (m_data.overrun !== want.overrun)
                    report_mismatch("overrun", m_data.overrun, want.overrun);
                if (m_data.first_in_bank !== want.first_in_bank)
                    report_mismatch("first_in_bank", m_data.first_in_bank, want.first_in_bank);
            end
            beats_checked++;
        end
    end

    // Result side stalls at random while idling is on.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(idle_en && $urandom_range(0, 99) < 23);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults: every command, the field extremes and each error but the third end marker once.
    task automatic test_directed();
        send_byte(set_ready);                 // ignored outside a message
        send_byte(8'hFF);                     // stray byte -> receiver reset
        send_byte(set_msg_start);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(set_msg_end);               // message length 2
        send_byte(set_data_start);
        send_sample_word(16'h00FF);           // first sample of bank 0
        send_sample_word(16'h0100);           // word over 255 -> reset
        send_item(CMD_NEW_FILE, 8'h00);
        send_item(CMD_SAVER_ACK, 8'hFF);
        send_item(CMD_EXT_RESET, 8'hA5);
        send_byte(set_data_start);
        send_byte(8'h61);                     // lowercase digit is not hex
        send_byte(set_data_start);
        send_byte(set_data_end);              // empty bank handed over
        drain_results();
    endtask

    // Small banks and short rows so both handover causes come often.
    task automatic test_small_banks();
        cfg_write(CFG_BANK_LIMIT, 7);
        cfg_write(CFG_CHANNEL_CNT, 3);
        run_traffic(400);
        drain_results();
    endtask

    // Zero limits clamp to one sample per bank; codes at their extremes.
    task automatic test_single_sample_banks();
        cfg_write(CFG_BANK_LIMIT, 0);
        cfg_write(CFG_CHANNEL_CNT, 0);
        cfg_write(CFG_MSG_START, 8'h00);
        cfg_write(CFG_MSG_END, 8'hFF);
        cfg_write(CFG_DATA_START, 8'h80);
        cfg_write(CFG_DATA_END, 8'h7F);
        cfg_write(CFG_READY, 8'hFE);
        run_traffic(200);
        drain_results();
    endtask

    // Full rate both ways for a long stretch.
    task automatic test_no_idle();
        idle_en = 1'b0;
        cfg_write(CFG_BANK_LIMIT, 5);
        cfg_write(CFG_CHANNEL_CNT, 4);
        cfg_write(CFG_MSG_START, 36);
        cfg_write(CFG_MSG_END, 13);
        cfg_write(CFG_DATA_START, 1);
        cfg_write(CFG_DATA_END, 2);
        cfg_write(CFG_READY, 3);
        run_traffic(300);
        drain_results();
        idle_en = 1'b1;
    endtask

    // Register values beyond the legal range clamp to the maxima.
    task automatic test_clamped_limits();
        cfg_write(CFG_BANK_LIMIT, 21'h1FFFFF);
        cfg_write(CFG_CHANNEL_CNT, 11'h7FF);
        run_traffic(80);
        drain_results();
        cfg_write(CFG_BANK_LIMIT, BANK_DEPTH);
        cfg_write(CFG_CHANNEL_CNT, MAX_CHANNEL);
        run_traffic(70);
        drain_results();
    endtask

    // Codes that collide with digits and with each other test the priority order.
    task automatic test_code_clash();
        repeat (3) begin
            cfg_write(CFG_BANK_LIMIT, $urandom_range(1, 9));
            cfg_write(CFG_CHANNEL_CNT, $urandom_range(1, 5));
            cfg_write(CFG_MSG_START, clash_code());
            cfg_write(CFG_MSG_END, clash_code());
            cfg_write(CFG_DATA_START, clash_code());
            cfg_write(CFG_DATA_END, clash_code());
            cfg_write(CFG_READY, clash_code());
            run_traffic(90);
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        // register defaults and a clean receiver, matching the block after reset
        set_limit      = LIMIT_MAX;
        set_chans      = 11'd200;
        set_msg_start  = 8'd36;
        set_msg_end    = 8'd13;
        set_data_start = 8'd1;
        set_data_end   = 8'd2;
        set_ready      = 8'd3;
        void'(receiver_abort(ERR_NONE));
        rx_switch_req  = 1'b0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_small_banks();
        test_single_sample_banks();
        test_no_idle();
        test_clamped_limits();
        test_code_clash();

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("hex_frame_receiver_double_bank_unit_tb: done, clean");
        end else begin
            $display("hex_frame_receiver_double_bank_unit_tb: done, errors");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("hex_frame_receiver_double_bank_unit_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
